// ===== rtl/core/adti_pkg.sv =====
// Shared types, codes and character helpers for the ASCII decimal parser.
`timescale 1ns / 1ps
`default_nettype none

package adti_pkg;

    // Parser phase codes.
    localparam int PhaseW = 3;
    localparam logic [PhaseW-1:0] PH_START = 3'd0;
    localparam logic [PhaseW-1:0] PH_LEAD  = 3'd1;
    localparam logic [PhaseW-1:0] PH_SIGN  = 3'd2;
    localparam logic [PhaseW-1:0] PH_DIGIT = 3'd3;
    localparam logic [PhaseW-1:0] PH_TRAIL = 3'd4;

    // Mode codes.
    localparam logic MODE_UNSIGNED = 1'b0;
    localparam logic MODE_SIGNED   = 1'b1;

    // Character codes.
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    // One input request.
    typedef struct packed {
        logic       mode;
        logic [7:0] char_byte;
        logic       last;
        logic       empty_req;
    } item_t;

    // One result.
    typedef struct packed {
        logic [63:0] unsigned_value;
        logic [31:0] signed_value;
        logic        ok;
    } result_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) || (c == CHAR_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/adti_parser.sv =====
// Parse state, per-character update and final range check of one request.
`timescale 1ns / 1ps
`default_nettype none

module adti_parser (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire adti_pkg::item_t  item,
    output logic                  res_valid,
    output adti_pkg::result_t     res
);
    import adti_pkg::*;

    logic [PhaseW-1:0] phase_reg, phase_next;
    logic [63:0]       acc_reg, acc_next;
    logic              neg_reg, neg_next;
    logic              seen_reg, seen_next;
    logic              fail_reg, fail_next;
    logic              mode_reg, mode_next;

    logic [PhaseW-1:0] ph_cur;
    logic              mode_cur;
    logic [67:0]       prod;
    logic [3:0]        dval;
    logic              c_blank;
    logic              c_digit;
    logic              c_sign;
    logic              neg_ok;
    logic              pos_ok;

    // Character classes and the times-ten-plus-digit product with carry-out.
    always_comb
    begin
        c_blank = is_blank(item.char_byte);
        c_digit = is_digit(item.char_byte);
        c_sign  = (item.char_byte == CHAR_PLUS) || (item.char_byte == CHAR_MINUS);
        dval    = item.char_byte[3:0];
        prod    = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {64'd0, dval};
    end

    // Per-character update of the parse state.
    always_comb
    begin
        ph_cur   = (phase_reg == PH_START) ? PH_LEAD : phase_reg;
        mode_cur = (phase_reg == PH_START) ? item.mode : mode_reg;
        phase_next = ph_cur;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        seen_next  = seen_reg;
        fail_next  = fail_reg;
        mode_next  = mode_cur;
        if (!fail_reg)
        begin
            case (ph_cur)
                PH_LEAD:
                begin
                    if (c_blank)
                    begin
                        phase_next = PH_LEAD;
                    end
                    else if (c_digit)
                    begin
                        seen_next  = 1'b1;
                        phase_next = PH_DIGIT;
                        if (prod[67:64] != 4'd0)
                            fail_next = 1'b1;
                        else
                            acc_next = prod[63:0];
                    end
                    else if ((mode_cur == MODE_SIGNED) && c_sign)
                    begin
                        neg_next   = (item.char_byte == CHAR_MINUS);
                        phase_next = PH_SIGN;
                    end
                    else
                    begin
                        fail_next = 1'b1;
                    end
                end
                PH_SIGN, PH_DIGIT:
                begin
                    if (c_digit)
                    begin
                        seen_next  = 1'b1;
                        phase_next = PH_DIGIT;
                        if (prod[67:64] != 4'd0)
                            fail_next = 1'b1;
                        else
                            acc_next = prod[63:0];
                    end
                    else if (c_blank)
                    begin
                        phase_next = PH_TRAIL;
                    end
                    else
                    begin
                        fail_next = 1'b1;
                    end
                end
                default:
                begin
                    if (!c_blank)
                        fail_next = 1'b1;
                end
            endcase
        end
    end

    // Range check and result forming on the last byte or an empty request.
    always_comb
    begin
        neg_ok = (acc_next[63:32] == 32'd0) && (!acc_next[31] || (acc_next[30:0] == 31'd0));
        pos_ok = (acc_next[63:31] == 33'd0);
        res_valid = item.last || item.empty_req;
        res.unsigned_value = 64'd0;
        res.signed_value   = 32'd0;
        res.ok             = 1'b0;
        if (!item.empty_req && !fail_next && seen_next)
        begin
            if (mode_cur == MODE_UNSIGNED)
            begin
                res.unsigned_value = acc_next;
                res.ok             = 1'b1;
            end
            else if (neg_next)
            begin
                if (neg_ok)
                begin
                    res.signed_value = 32'd0 - acc_next[31:0];
                    res.ok           = 1'b1;
                end
            end
            else if (pos_ok)
            begin
                res.signed_value = acc_next[31:0];
                res.ok           = 1'b1;
            end
        end
    end

    // State registers; every result returns the parser to the start phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            acc_reg   <= 64'd0;
            neg_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            fail_reg  <= 1'b0;
            mode_reg  <= MODE_UNSIGNED;
        end
        else if (step)
        begin
            if (res_valid)
            begin
                phase_reg <= PH_START;
                acc_reg   <= 64'd0;
                neg_reg   <= 1'b0;
                seen_reg  <= 1'b0;
                fail_reg  <= 1'b0;
                mode_reg  <= MODE_UNSIGNED;
            end
            else
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                seen_reg  <= seen_next;
                fail_reg  <= fail_next;
                mode_reg  <= mode_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/adti_out_reg.sv =====
// Result register with valid/ready handshake toward the consumer.
`timescale 1ns / 1ps
`default_nettype none

module adti_out_reg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire logic               load,
    input  wire adti_pkg::result_t  res_in,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output logic                    free,
    output adti_pkg::result_t       res_out
);
    import adti_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    // The register can take new data when empty or when its result is taken.
    always_comb
    begin
        free       = !valid_reg || out_ready;
        valid_next = advance ? load : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload loads only with a new result.
    always_ff @(posedge clk)
    begin
        if (advance && load)
            data_reg <= res_in;
    end

    assign out_valid = valid_reg;
    assign res_out   = data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ascii_decimal_to_integer_unit.sv =====
// A request is parsed from the input register and its result held in the result register.
// Throughput: one byte per cycle; the input register, the single-pass parse logic
// and the result register all advance together whenever the result register is free.
// The parse path is one 68-bit times-ten add with carry-out check per byte.
// Reset: rst_n clears the parser to the start phase and empties both registers.
`timescale 1ns / 1ps
`default_nettype none

module ascii_decimal_to_integer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        mode,
    input  wire logic [7:0]  char_byte,
    input  wire logic        last,
    input  wire logic        empty_req,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      unsigned_value,
    output logic [31:0]      signed_value,
    output logic             ok
);
    import adti_pkg::*;

    logic    in_valid_reg, in_valid_next;
    item_t   item_reg;
    logic    advance;
    logic    step;
    logic    res_valid;
    result_t res;
    result_t res_q;
    logic    free_out;

    // The whole pipe moves when the result register can take data.
    assign advance  = free_out;
    assign in_ready = !in_valid_reg || advance;
    assign step     = in_valid_reg && advance;

    // Input register.
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ready)
            in_valid_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.mode      <= mode;
            item_reg.char_byte <= char_byte;
            item_reg.last      <= last;
            item_reg.empty_req <= empty_req;
        end
    end

    // Parser and result register.
    adti_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (item_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    adti_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .load      (step && res_valid),
        .res_in    (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .free      (free_out),
        .res_out   (res_q)
    );

    assign unsigned_value = res_q.unsigned_value;
    assign signed_value   = res_q.signed_value;
    assign ok             = res_q.ok;

endmodule

`default_nettype wire

// ===== tb/sv/ascii_decimal_to_integer_unit_test.sv =====
// Self-checking testbench for the ASCII decimal to integer parser unit.
`timescale 1ns / 1ps

module ascii_decimal_to_integer_unit_test;
    import adti_pkg::*;

    localparam int RandomBytes   = 420;
    localparam int WatchdogLimit = 2000;
    localparam int HoldStart     = 150;
    localparam int HoldEnd       = 420;
    localparam int DrainCycles   = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        mode = MODE_UNSIGNED;
    logic [7:0]  char_byte = 8'h00;
    logic        last = 1'b0;
    logic        empty_req = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] unsigned_value;
    logic [31:0] signed_value;
    logic        ok;

    // Parser state tracked by the testbench.
    logic [PhaseW-1:0] parse_phase = PH_START;
    logic [63:0]       digit_acc = '0;
    logic              neg_sign = 1'b0;
    logic              digit_taken = 1'b0;
    logic              parse_failed = 1'b0;
    logic              string_mode = MODE_UNSIGNED;

    item_t       pending_bytes[$];
    result_t     expected_results[$];
    logic [7:0]  text_buf[$];
    item_t       current;
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          rx_cycle = 0;
    int          burst_left = 1;
    int          gap_left = 0;

    always #5 clk = ~clk;

    ascii_decimal_to_integer_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .char_byte      (char_byte),
        .last           (last),
        .empty_req      (empty_req),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .unsigned_value (unsigned_value),
        .signed_value   (signed_value),
        .ok             (ok)
    );

    // Whitespace accepted around the number.
    function automatic logic blank_char(input logic [7:0] c);
        case (c)
            CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_CR: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic decimal_char(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    task automatic clear_parser();
        parse_phase  = PH_START;
        digit_acc    = '0;
        neg_sign     = 1'b0;
        digit_taken  = 1'b0;
        parse_failed = 1'b0;
        string_mode  = MODE_UNSIGNED;
    endtask

    // Multiply-by-ten accumulation; overflow past 64 bits sticks as a failure.
    task automatic accumulate_digit(input logic [7:0] c);
        logic [63:0] d;
        d = {56'd0, c - CHAR_ZERO};
        digit_taken = 1'b1;
        if (digit_acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10)
        begin
            parse_failed = 1'b1;
        end
        else
        begin
            digit_acc = digit_acc * 64'd10 + d;
        end
    endtask

    // Advance the parser by one request and queue the result it produces, if any.
    task automatic parse_byte(input item_t it);
        result_t     res;
        logic [7:0]  c;
        logic [63:0] neg_val;
        res = '0;
        c = it.char_byte;
        if (it.empty_req)
        begin
            clear_parser();
            expected_results.push_back(res);
            return;
        end
        if (parse_phase == PH_START)
        begin
            string_mode = it.mode;
            parse_phase = PH_LEAD;
        end
        if (!parse_failed)
        begin
            case (parse_phase)
                PH_LEAD:
                begin
                    if (blank_char(c))
                    begin
                        parse_phase = PH_LEAD;
                    end
                    else if (decimal_char(c))
                    begin
                        accumulate_digit(c);
                        parse_phase = PH_DIGIT;
                    end
                    else if (string_mode == MODE_SIGNED && (c == CHAR_PLUS || c == CHAR_MINUS))
                    begin
                        neg_sign = (c == CHAR_MINUS);
                        parse_phase = PH_SIGN;
                    end
                    else
                    begin
                        parse_failed = 1'b1;
                    end
                end
                PH_SIGN, PH_DIGIT:
                begin
                    if (decimal_char(c))
                    begin
                        accumulate_digit(c);
                        parse_phase = PH_DIGIT;
                    end
                    else if (blank_char(c))
                    begin
                        parse_phase = PH_TRAIL;
                    end
                    else
                    begin
                        parse_failed = 1'b1;
                    end
                end
                default:
                begin
                    if (!blank_char(c))
                    begin
                        parse_failed = 1'b1;
                    end
                end
            endcase
        end
        if (!it.last)
        begin
            return;
        end
        // Final byte: range check for the selected mode.
        if (!parse_failed && digit_taken)
        begin
            if (string_mode == MODE_UNSIGNED)
            begin
                res.unsigned_value = digit_acc;
                res.ok = 1'b1;
            end
            else if (neg_sign)
            begin
                if (digit_acc <= 64'd2147483648)
                begin
                    neg_val = 64'd0 - digit_acc;
                    res.signed_value = neg_val[31:0];
                    res.ok = 1'b1;
                end
            end
            else if (digit_acc <= 64'd2147483647)
            begin
                res.signed_value = digit_acc[31:0];
                res.ok = 1'b1;
            end
        end
        expected_results.push_back(res);
        clear_parser();
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("%0t ns: %s got %0h, expected %0h", $time, field, got, want);
    endtask

    // Stimulus builders working on the text buffer.
    task automatic add_chars(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            text_buf.push_back(s[i]);
        end
    endtask

    task automatic add_blanks(input int n);
        logic [7:0] b;
        repeat (n)
        begin
            case ($urandom_range(0, 3))
                0: b = CHAR_SPACE;
                1: b = CHAR_TAB;
                2: b = CHAR_LF;
                default: b = CHAR_CR;
            endcase
            text_buf.push_back(b);
        end
    endtask

    task automatic add_random_number(input logic m);
        logic [63:0] v;
        int          n;
        case ($urandom_range(0, 4))
            0:
            begin
                n = (m == MODE_SIGNED) ? $urandom_range(1, 11) : $urandom_range(1, 22);
                repeat (n)
                begin
                    text_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
                end
            end
            1:
            begin
                if (m == MODE_SIGNED)
                begin
                    v = 64'd2147483646 + $urandom_range(0, 3);
                end
                else
                begin
                    v = 64'hFFFF_FFFF_FFFF_FFFC + $urandom_range(0, 3);
                end
                add_chars($sformatf("%0d", v));
            end
            default:
            begin
                if (m == MODE_SIGNED)
                begin
                    v = {32'd0, $urandom} >> $urandom_range(0, 31);
                end
                else
                begin
                    v = {$urandom, $urandom} >> $urandom_range(0, 63);
                end
                add_chars($sformatf("%0d", v));
            end
        endcase
    endtask

    // Turn the text buffer into requests; an empty buffer becomes an empty request.
    // Without finish the string is cut short and abandoned by an empty request.
    task automatic emit_text(input logic m, input logic finish);
        item_t it;
        for (int i = 0; i < text_buf.size(); i++)
        begin
            it.mode = (i == 0) ? m : logic'($urandom_range(0, 1));
            it.char_byte = text_buf[i];
            it.last = finish && (i == text_buf.size() - 1);
            it.empty_req = 1'b0;
            pending_bytes.push_back(it);
        end
        if (text_buf.size() == 0 || !finish)
        begin
            it.mode = logic'($urandom_range(0, 1));
            it.char_byte = 8'($urandom_range(0, 255));
            it.last = logic'($urandom_range(0, 1));
            it.empty_req = 1'b1;
            pending_bytes.push_back(it);
        end
        text_buf.delete();
    endtask

    task automatic queue_text(input logic m, input string s);
        add_chars(s);
        emit_text(m, 1'b1);
    endtask

    // Input driver: bursts of requests separated by random gaps.
    always @(posedge clk)
    begin : request_driver
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                parse_byte(current);
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    current = pending_bytes.pop_front();
                    in_valid  <= 1'b1;
                    mode      <= current.mode;
                    char_byte <= current.char_byte;
                    last      <= current.last;
                    empty_req <= current.empty_req;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = $urandom_range(0, 7);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: a long hold-off early on, then rotating stall patterns.
    always @(posedge clk)
    begin : result_receiver
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            rx_cycle++;
            if (rx_cycle >= HoldStart && rx_cycle < HoldEnd)
            begin
                out_ready <= 1'b0;
            end
            else
            begin
                case ((rx_cycle / 50) % 4)
                    0: out_ready <= 1'b1;
                    1: out_ready <= logic'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 3) != 0);
                    default: out_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Compare every accepted result against the oldest expectation.
    always @(posedge clk)
    begin : result_checker
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result", unsigned_value, 64'd0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (unsigned_value !== want.unsigned_value)
                begin
                    report_mismatch("unsigned_value", unsigned_value, want.unsigned_value);
                end
                if (signed_value !== want.signed_value)
                begin
                    report_mismatch("signed_value", {32'd0, signed_value},
                                    {32'd0, want.signed_value});
                end
                if (ok !== want.ok)
                begin
                    report_mismatch("ok", {63'd0, ok}, {63'd0, want.ok});
                end
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WatchdogLimit)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Build the request stream, release reset and wait for the drain.
    initial
    begin : stimulus
        logic m;
        int   kind;
        int   base;

        // Value extremes in both modes.
        queue_text(MODE_UNSIGNED, "0");
        queue_text(MODE_UNSIGNED, "18446744073709551615");
        queue_text(MODE_UNSIGNED, "18446744073709551616");
        queue_text(MODE_UNSIGNED, " \t42\r\n");
        queue_text(MODE_SIGNED, "-2147483648");
        queue_text(MODE_SIGNED, "-2147483649");
        queue_text(MODE_SIGNED, "+2147483647");
        queue_text(MODE_SIGNED, "2147483648");
        queue_text(MODE_SIGNED, "-0");
        // Malformed strings.
        queue_text(MODE_SIGNED, " \r\n\t");
        queue_text(MODE_SIGNED, "-");
        queue_text(MODE_UNSIGNED, "+5");
        queue_text(MODE_SIGNED, "+-5");
        queue_text(MODE_SIGNED, "+ -5");
        queue_text(MODE_SIGNED, "5-");
        queue_text(MODE_UNSIGNED, "1 2");
        queue_text(MODE_UNSIGNED, "1x");
        queue_text(MODE_UNSIGNED, "x12345 ");
        text_buf.push_back(8'h00);
        emit_text(MODE_UNSIGNED, 1'b1);
        text_buf.push_back(8'hFF);
        emit_text(MODE_SIGNED, 1'b1);
        // Empty request alone, and one that abandons a string in progress.
        emit_text(MODE_SIGNED, 1'b1);
        add_chars("12");
        emit_text(MODE_UNSIGNED, 1'b0);
        queue_text(MODE_UNSIGNED, "7");

        // Random part: mostly well-formed numbers, some corrupted, some noise.
        base = pending_bytes.size();
        while (pending_bytes.size() < base + RandomBytes)
        begin
            m = logic'($urandom_range(0, 1));
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                repeat ($urandom_range(0, 6))
                begin
                    text_buf.push_back(8'($urandom_range(0, 255)));
                end
            end
            else
            begin
                add_blanks($urandom_range(0, 2));
                if ((m == MODE_SIGNED || kind == 3) && $urandom_range(0, 2) != 0)
                begin
                    text_buf.push_back($urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS);
                end
                add_random_number(m);
                add_blanks($urandom_range(0, 2));
                if (kind <= 2)
                begin
                    text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
                end
            end
            emit_text(m, $urandom_range(0, 24) != 0);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (DrainCycles) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/adti_pkg.sv
rtl/core/adti_parser.sv
rtl/core/adti_out_reg.sv
rtl/core/ascii_decimal_to_integer_unit.sv
tb/sv/ascii_decimal_to_integer_unit_test.sv
